/* rtl/imm_pkg.sv */
// Package for the integer matrix multiplier: sizes, field widths, command and
// register codes, and the helpers for store addressing and dimension clamping.
// No dependencies.
package imm_pkg;

  // Matrix and element sizes.
  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths of the request and result items.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int PAY_W     = POS_W + POS_W + VAL_W;
  localparam int TDATA_W   = ((PAY_W + 7) / 8) * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_A   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // Store address of element (r, c), row major.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
    addr_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

  // Zero counts as one, anything above the store size as the store size.
  function automatic logic [CNT_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      eff_dim = CNT_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      eff_dim = CNT_W'(MAX_DIM);
    end else begin
      eff_dim = CNT_W'(d);
    end
  endfunction

endpackage

/* rtl/integer_matrix_multiply.sv */
// Integer matrix multiplier top level: element stores, sequencer, MAC pipeline
// and output register. Depends on imm_pkg.
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: row, col, value
// m_*      out  m_tvalid/m_tready  tuser: size_error; tlast: last;
//                                  tdata: out_row, out_col, product
// cfg_*    in   cfg_valid/cfg_ready register index and 4-bit dimension
//
// A multiply walks the m*q product elements: each product element issues n
// reads of both stores, one per cycle, through the single read port of each
// memory and the shared multiply-accumulate unit, then waits for the pipeline
// to drain and for the hand-over. A size error gives a single result, marked
// last. Reset (rst, synchronous) clears control state and sets the dimension
// registers to MAX_DIM; the stores are not cleared. A stalled result holds the
// sequencer until the output register frees.
module integer_matrix_multiply (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [imm_pkg::CMD_W-1:0]     s_tuser,  // [1:0] cmd
  input  logic [imm_pkg::TDATA_W-1:0]   s_tdata,  // [2:0] row, [5:3] col, [37:6] value
  // Result channel.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tlast,
  output logic [0:0]                    m_tuser,  // [0] size_error
  output logic [imm_pkg::TDATA_W-1:0]   m_tdata,  // [2:0] out_row, [5:3] out_col,
                                                  // [37:6] product
  // Configuration channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]     cfg_data
);
  import imm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_ERR   = 4'b1000
  } state_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic fin;
  } mac_ctrl_t;

  // Request fields.
  logic [CMD_W-1:0] in_cmd;
  logic [POS_W-1:0] in_row;
  logic [POS_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;

  assign in_cmd   = s_tuser;
  assign in_row   = s_tdata[POS_W-1:0];
  assign in_col   = s_tdata[2*POS_W-1:POS_W];
  assign in_value = s_tdata[PAY_W-1:2*POS_W];

  // Dimension registers.
  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_RESET;
      a_cols <= DIM_RESET;
      b_rows <= DIM_RESET;
      b_cols <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_A_ROWS: a_rows <= cfg_data;
        REG_A_COLS: a_cols <= cfg_data;
        REG_B_ROWS: b_rows <= cfg_data;
        REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions and the last index of each loop.
  logic [CNT_W-1:0] m_eff, n_eff, p_eff, q_eff;
  logic [IDX_W-1:0] i_last, k_last, j_last;

  assign m_eff  = eff_dim(a_rows);
  assign n_eff  = eff_dim(a_cols);
  assign p_eff  = eff_dim(b_rows);
  assign q_eff  = eff_dim(b_cols);
  assign i_last = IDX_W'(m_eff - CNT_W'(1));
  assign k_last = IDX_W'(n_eff - CNT_W'(1));
  assign j_last = IDX_W'(q_eff - CNT_W'(1));

  state_t           state;
  logic [IDX_W-1:0] i, j, k;

  // Request decode.
  logic in_req, load_in_range, load_a, load_b, mul_req;
  logic [ADDR_W-1:0] waddr;

  assign s_tready      = (state == ST_IDLE);
  assign in_req        = s_tvalid && s_tready;
  assign load_in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign waddr         = addr_of(IDX_W'(in_row), IDX_W'(in_col));
  assign load_a        = in_req && (in_cmd == CMD_LOAD_A) && load_in_range;
  assign load_b        = in_req && (in_cmd == CMD_LOAD_B) && load_in_range;
  assign mul_req       = in_req && (in_cmd == CMD_MULTIPLY);

  // Element stores, one write and one registered read port each.
  logic [DATA_WIDTH-1:0] a_mem [0:DEPTH-1];
  logic [DATA_WIDTH-1:0] b_mem [0:DEPTH-1];
  logic [DATA_WIDTH-1:0] a_rd, b_rd;
  logic [ADDR_W-1:0]     a_raddr, b_raddr;

  assign a_raddr = addr_of(i, k);
  assign b_raddr = addr_of(k, j);

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_mem[waddr] <= DATA_WIDTH'(in_value);
    end
    a_rd <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_mem[waddr] <= DATA_WIDTH'(in_value);
    end
    b_rd <= b_mem[b_raddr];
  end

  // Output register hand-over.
  logic out_free, out_load, sum_ready, elem_last;

  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = ((state == ST_DRAIN) && sum_ready && out_free) ||
                     ((state == ST_ERR) && out_free);
  assign elem_last = (i == i_last) && (j == j_last);

  // Sequencer over i, j and k.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (mul_req) begin
            state <= (n_eff != p_eff) ? ST_ERR : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k == k_last) begin
            state <= ST_DRAIN;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            k <= '0;
            if (elem_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_ISSUE;
              if (j == j_last) begin
                j <= '0;
                i <= i + IDX_W'(1);
              end else begin
                j <= j + IDX_W'(1);
              end
            end
          end
        end
        ST_ERR: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  mac_ctrl_t             c0, c1, c2;
  logic [DATA_WIDTH-1:0] mul_full;
  logic [DATA_WIDTH-1:0] mul;
  logic [DATA_WIDTH-1:0] acc;

  // The sum wraps at the element width, so only the low half of each product is kept.
  assign c0.vld   = (state == ST_ISSUE);
  assign c0.first = (k == '0);
  assign c0.fin   = (k == k_last);
  assign mul_full = a_rd * b_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
    end else begin
      c1 <= c0;
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    mul <= mul_full;
    if (c2.vld) begin
      acc <= (c2.first ? '0 : acc) + mul;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ready <= 1'b0;
    end else if (c2.vld && c2.fin) begin
      sum_ready <= 1'b1;
    end else if (out_load) begin
      sum_ready <= 1'b0;
    end
  end

  // Output register.
  logic [POS_W-1:0] out_row, out_col;
  logic [VAL_W-1:0] product;
  logic             last, size_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_ERR) begin
        out_row    <= '0;
        out_col    <= '0;
        product    <= '0;
        last       <= 1'b1;
        size_error <= 1'b1;
      end else begin
        out_row    <= POS_W'(i);
        out_col    <= POS_W'(j);
        product    <= VAL_W'(acc);
        last       <= elem_last;
        size_error <= 1'b0;
      end
    end
  end

  assign m_tdata = TDATA_W'({product, out_col, out_row});
  assign m_tlast = last;
  assign m_tuser = size_error;

  // A finished sum only waits while the sequencer is draining.
  a_sum_in_drain: assert property (@(posedge clk) disable iff (rst)
    sum_ready |-> (state == ST_DRAIN))
    else $error("sum ready outside drain");

  // Pipeline work only exists during a product walk.
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    (c1.vld || c2.vld) |-> ((state == ST_ISSUE) || (state == ST_DRAIN)))
    else $error("MAC pipeline busy outside a walk");

  // The final term of a sum makes the sum ready in the next cycle.
  a_fin_ready: assert property (@(posedge clk) disable iff (rst)
    (c2.vld && c2.fin) |=> sum_ready)
    else $error("sum not ready after final term");

  // A size error result is always the last of its multiply.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("size error without last");

endmodule

/* verif/integer_matrix_multiply_checker.sv */
// Checker for the integer matrix multiplier: watches the request, result and
// configuration channels, predicts every product element and compares them.
// Depends on imm_pkg.
module integer_matrix_multiply_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [imm_pkg::CMD_W-1:0]     s_tuser,
  input  logic [imm_pkg::TDATA_W-1:0]   s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          m_tlast,
  input  logic [0:0]                    m_tuser,
  input  logic [imm_pkg::TDATA_W-1:0]   m_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import imm_pkg::*;

  // One element of C, or the single size error result.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [VAL_W-1:0] product;
    logic             last;
    logic             size_error;
  } element_t;

  logic [VAL_W-1:0] a_elems [DEPTH];
  logic [VAL_W-1:0] b_elems [DEPTH];
  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  element_t         product_queue [$];
  int               mismatches  = 0;
  int               outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // A zero dimension counts as one, anything above the store size as the store size.
  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end
    if (d > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(d);
  endfunction

  // Work out all results of a multiply from the current stores and sizes.
  function automatic void queue_products();
    int               m, n, p, q, i, j, k;
    logic [VAL_W-1:0] acc;
    element_t         r;
    m = clamp_dim(a_rows);
    n = clamp_dim(a_cols);
    p = clamp_dim(b_rows);
    q = clamp_dim(b_cols);
    if (n != p) begin
      r = '{row: '0, col: '0, product: '0, last: 1'b1, size_error: 1'b1};
      product_queue.push_back(r);
    end else begin
      for (i = 0; i < m; i++) begin
        for (j = 0; j < q; j++) begin
          // The sum wraps at the element width, so low-order products suffice.
          acc = '0;
          for (k = 0; k < n; k++) begin
            acc = acc + a_elems[i * MAX_DIM + k] * b_elems[k * MAX_DIM + j];
          end
          r.row        = POS_W'(i);
          r.col        = POS_W'(j);
          r.product    = acc;
          r.last       = (i == m - 1) && (j == q - 1);
          r.size_error = 1'b0;
          product_queue.push_back(r);
        end
      end
    end
  endfunction

  // Apply one accepted request to the stores or start a multiply.
  task automatic take_request();
    logic [POS_W-1:0] r, c;
    logic [VAL_W-1:0] v;
    r = s_tdata[POS_W-1:0];
    c = s_tdata[2*POS_W-1:POS_W];
    v = s_tdata[2*POS_W +: VAL_W];
    case (s_tuser)
      CMD_LOAD_A: begin
        if (r < MAX_DIM && c < MAX_DIM) a_elems[int'(r) * MAX_DIM + int'(c)] = v;
      end
      CMD_LOAD_B: begin
        if (r < MAX_DIM && c < MAX_DIM) b_elems[int'(r) * MAX_DIM + int'(c)] = v;
      end
      CMD_MULTIPLY: begin
        queue_products();
      end
      default: begin
        // The spare command code does nothing.
      end
    endcase
  endtask

  // Compare one accepted result with the oldest outstanding element.
  task automatic check_result();
    element_t got, want;
    got = '{row: m_tdata[POS_W-1:0], col: m_tdata[2*POS_W-1:POS_W],
            product: m_tdata[2*POS_W +: VAL_W], last: m_tlast, size_error: m_tuser[0]};
    if (product_queue.size() == 0) begin
      report_mismatch($sformatf("result row %0d col %0d with nothing outstanding",
                                got.row, got.col));
    end else begin
      want = product_queue.pop_front();
      if (got.row !== want.row)
        report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report_mismatch($sformatf("out_col %0d, want %0d", got.col, want.col));
      if (got.product !== want.product)
        report_mismatch($sformatf("product %h at (%0d,%0d), want %h", got.product,
                                  want.row, want.col, want.product));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b at (%0d,%0d), want %b", got.last,
                                  want.row, want.col, want.last));
      if (got.size_error !== want.size_error)
        report_mismatch($sformatf("size_error %b, want %b", got.size_error,
                                  want.size_error));
    end
  endtask

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      a_rows = DIM_RESET;
      a_cols = DIM_RESET;
      b_rows = DIM_RESET;
      b_cols = DIM_RESET;
      product_queue.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_A_ROWS: a_rows = cfg_data;
          REG_A_COLS: a_cols = cfg_data;
          REG_B_ROWS: b_rows = cfg_data;
          REG_B_COLS: b_cols = cfg_data;
          default: begin
            // Indexes past the register list are ignored.
          end
        endcase
      end
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        check_result();
      end
      if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
        take_request();
      end
    end
    outstanding = product_queue.size();
  end

endmodule

/* verif/integer_matrix_multiply_tb.sv */
// Testbench top for the integer matrix multiplier: clock, reset, request and
// configuration stimulus, result back-pressure and the verdict.
// Depends on imm_pkg, integer_matrix_multiply and integer_matrix_multiply_checker.
module integer_matrix_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imm_pkg::*;

  localparam int                   ITEM_TARGET   = 110;
  localparam int                   FINAL_RESERVE = 35;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   SETTLE_CYCLES = 8;
  localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd4;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [CMD_W-1:0]     s_tuser;
  logic [TDATA_W-1:0]   s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic                 m_tlast;
  logic [0:0]           m_tuser;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;

  // Sizes as last written, and which store entries hold a loaded value.
  logic [DIM_W-1:0] dims [4];
  logic [DEPTH-1:0] a_written;
  logic [DEPTH-1:0] b_written;
  bit               gaps_on;
  bit               long_hold;
  int               items_sent;

  integer_matrix_multiply dut (.*);

  integer_matrix_multiply_checker product_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Overall limit on the run.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        m_tready  = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offer one request, leaving tvalid high after acceptance for the next one.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = TDATA_W'({value, col, row});
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic load_element(input bit to_b, input logic [POS_W-1:0] row,
                              input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value);
    send_request(to_b ? CMD_LOAD_B : CMD_LOAD_A, row, col, value);
    if (to_b) begin
      b_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    end else begin
      a_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
    end
  endtask

  // Mostly full-range words, often the extremes and small signed values.
  function automatic logic [VAL_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3:       return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Mostly small sizes; now and then up to the field maximum.
  function automatic logic [DIM_W-1:0] random_dim();
    if ($urandom_range(0, 5) == 0) return DIM_W'($urandom_range(4, 15));
    return DIM_W'($urandom_range(0, 3));
  endfunction

  // When the inner sizes agree, load every entry the multiply will read that has never been written; then multiply.
  task automatic request_multiply();
    int m, n, p, q, i, j, k;
    m = int'(eff_dim(dims[2'(REG_A_ROWS)]));
    n = int'(eff_dim(dims[2'(REG_A_COLS)]));
    p = int'(eff_dim(dims[2'(REG_B_ROWS)]));
    q = int'(eff_dim(dims[2'(REG_B_COLS)]));
    if (n == p) begin
      for (i = 0; i < m; i++) begin
        for (k = 0; k < n; k++) begin
          if (!a_written[i * MAX_DIM + k]) load_element(1'b0, POS_W'(i), POS_W'(k), rand_word());
        end
      end
      for (k = 0; k < n; k++) begin
        for (j = 0; j < q; j++) begin
          if (!b_written[k * MAX_DIM + j]) load_element(1'b1, POS_W'(k), POS_W'(j), rand_word());
        end
      end
    end
    send_request(CMD_MULTIPLY, POS_W'($urandom), POS_W'($urandom), rand_word());
  endtask

  // Stop offering requests until every outstanding result has arrived.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx <= REG_B_COLS) dims[2'(idx)] = data;
  endtask

  // Sizes change only once the block is idle, loads included.
  task automatic set_dims(input logic [DIM_W-1:0] ar, ac, br, bc);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(REG_A_ROWS, ar);
    write_register(REG_A_COLS, ac);
    write_register(REG_B_ROWS, br);
    write_register(REG_B_COLS, bc);
    if ($urandom_range(0, 3) == 0) begin
      write_register(REG_SPARE + CFG_IDX_W'($urandom_range(0, 3)), DIM_W'($urandom));
    end
  endtask

  initial begin
    int               ops;
    int               phase;
    logic [DIM_W-1:0] inner;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tuser    = '0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gaps_on    = 1'b1;
    long_hold  = 1'b0;
    items_sent = 0;
    a_written  = '0;
    b_written  = '0;
    dims       = '{default: DIM_RESET};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one by one products at the value extremes.
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    write_register(REG_SPARE + 3'd3, '1);
    load_element(1'b0, 3'd0, 3'd0, 32'h8000_0000);
    load_element(1'b1, 3'd0, 3'd0, 32'h8000_0000);
    request_multiply();
    send_request(CMD_UNUSED, 3'd7, 3'd7, '1);
    load_element(1'b0, 3'd0, 3'd0, 32'h7fff_ffff);
    load_element(1'b1, 3'd0, 3'd0, 32'h7fff_ffff);
    request_multiply();
    load_element(1'b0, 3'd0, 3'd0, '1);
    request_multiply();
    load_element(1'b0, 3'd7, 3'd7, '1);
    load_element(1'b1, 3'd7, 3'd7, 32'h8000_0000);

    // Directed: size mismatch, zero sizes, and a mismatch with an inner size above the store size.
    set_dims(4'd1, 4'd2, 4'd3, 4'd1);
    request_multiply();
    set_dims(4'd0, 4'd0, 4'd1, 4'd0);
    request_multiply();
    set_dims(4'd1, 4'd12, 4'd3, 4'd1);
    request_multiply();

    // Random phases, each under a new set of sizes; the long stall always comes.
    phase = 0;
    while (items_sent < ITEM_TARGET - FINAL_RESERVE || phase <= 2) begin
      if (phase == 2) begin
        // Stall the result side for a long stretch while requests keep coming.
        set_dims(4'd3, 4'd2, 4'd2, 4'd3);
        request_multiply();
        drain();
        long_hold = 1'b1;
        request_multiply();
        repeat (4) load_element(1'($urandom_range(0, 1)), POS_W'($urandom),
                                POS_W'($urandom), rand_word());
        request_multiply();
      end else begin
        inner = random_dim();
        set_dims(random_dim(), inner,
                 ($urandom_range(0, 4) == 0) ? random_dim() : inner, random_dim());
      end
      ops = $urandom_range(2, 8);
      repeat (ops) begin
        case ($urandom_range(0, 9))
          0: send_request(CMD_UNUSED, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
          1, 2, 3: begin
            request_multiply();
            if ($urandom_range(0, 3) == 0) drain();
          end
          default: load_element(1'($urandom_range(0, 1)), POS_W'($urandom),
                                POS_W'($urandom), rand_word());
        endcase
      end
      request_multiply();
      phase++;
    end

    // Final part with a full-size, clamped result grid and no idling on either side.
    gaps_on = 1'b0;
    set_dims(4'd15, 4'd2, 4'd2, 4'd12);
    request_multiply();
    repeat (3) load_element(1'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom),
                            rand_word());
    request_multiply();

    drain();
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
